>>> sv/qlu_pkg.sv
// ----------------------------------------------------------------------------
// qlu_pkg
// Shared types, character codes, status codes and helper functions for the
// quoted literal unescaper.
// ----------------------------------------------------------------------------
package qlu_pkg;

  // parse phases, one-hot
  typedef enum logic [6:0] {
    PH_START  = 7'b000_0001,
    PH_AFTER_B = 7'b000_0010,
    PH_BODY   = 7'b000_0100,
    PH_ESC    = 7'b000_1000,
    PH_HEX    = 7'b001_0000,
    PH_UTF    = 7'b010_0000,
    PH_CLOSED = 7'b100_0000
  } phase_t;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PREFIX   = 3'd1;
  localparam logic [2:0] ST_ESCAPE   = 3'd2;
  localparam logic [2:0] ST_HEX      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_UTF8     = 3'd5;
  localparam logic [2:0] ST_EARLY    = 3'd6;
  localparam logic [2:0] ST_UNCLOSED = 3'd7;

  // characters
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_UU  = 8'h55;

  // UTF-8 range limits
  localparam logic [31:0] CP_MAX1 = 32'h0000_007F;
  localparam logic [31:0] CP_MAX2 = 32'h0000_07FF;
  localparam logic [31:0] CP_MAX3 = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX4 = 32'h0010_FFFF;

  localparam int MAX_BYTES = 4;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
  } enc_t;

  // results of one input transaction: data bytes, then optional status
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic                      has_stat;
    logic [2:0]                stat;
  } bundle_t;

  function automatic enc_t utf8_enc(input logic [31:0] v);
    enc_t e;
    e = '0;
    if (v <= CP_MAX1) begin
      e.bytes[0] = v[7:0];
      e.nbytes   = 3'd1;
    end else if (v <= CP_MAX2) begin
      e.bytes[0] = {3'b110, v[10:6]};
      e.bytes[1] = {2'b10, v[5:0]};
      e.nbytes   = 3'd2;
    end else if (v <= CP_MAX3) begin
      e.bytes[0] = {4'b1110, v[15:12]};
      e.bytes[1] = {2'b10, v[11:6]};
      e.bytes[2] = {2'b10, v[5:0]};
      e.nbytes   = 3'd3;
    end else if (v <= CP_MAX4) begin
      e.bytes[0] = {5'b11110, v[20:18]};
      e.bytes[1] = {2'b10, v[17:12]};
      e.bytes[2] = {2'b10, v[11:6]};
      e.bytes[3] = {2'b10, v[5:0]};
      e.nbytes   = 3'd4;
    end
    return e;
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {ok, value}
  function automatic logic [8:0] simple_esc(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CH_BSL:  r = {1'b1, 8'h5C};
      CH_SQ:   r = {1'b1, 8'h27};
      CH_DQ:   r = {1'b1, 8'h22};
      8'h61:   r = {1'b1, 8'h07};
      CH_B:    r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      8'h76:   r = {1'b1, 8'h0B};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/qlu_parse.sv
// ----------------------------------------------------------------------------
// qlu_parse
// Parser state and single-pass decode of one literal byte into a result
// bundle (up to four data bytes and the final status).
// ----------------------------------------------------------------------------
module qlu_parse import qlu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output bundle_t    bnd
);

  phase_t      phase, phase_next, phase_a;
  logic        byte_mode, byte_mode_next, byte_mode_a;
  logic        quote_dbl, quote_dbl_next, quote_dbl_a;
  logic [31:0] hex_acc, hex_acc_next, hex_acc_a;
  logic [3:0]  digits_left, digits_left_next, digits_left_a;
  logic [20:0] cp_acc, cp_acc_next, cp_acc_a;
  logic [1:0]  cont_left, cont_left_next, cont_left_a;
  logic [2:0]  err, err_next, err_a;

  logic        raw_req, emit_req;
  logic [31:0] emit_v;
  logic [4:0]  hv;
  logic [8:0]  sv;
  logic [7:0]  qch;
  enc_t        enc;

  assign hv  = hex_val(byte_in);
  assign sv  = simple_esc(byte_in);
  assign qch = quote_dbl ? CH_DQ : CH_SQ;

  // decode
  always_comb begin
    phase_a       = phase;
    byte_mode_a   = byte_mode;
    quote_dbl_a   = quote_dbl;
    hex_acc_a     = hex_acc;
    digits_left_a = digits_left;
    cp_acc_a      = cp_acc;
    cont_left_a   = cont_left;
    err_a         = err;
    raw_req       = 1'b0;
    emit_req      = 1'b0;
    emit_v        = '0;
    if (err == ST_OK) begin
      case (phase)
        PH_START: begin
          if (byte_in == CH_B) begin
            phase_a = PH_AFTER_B;
          end else if (byte_in == CH_SQ || byte_in == CH_DQ) begin
            quote_dbl_a = (byte_in == CH_DQ);
            phase_a     = PH_BODY;
          end else begin
            err_a = ST_PREFIX;
          end
        end
        PH_AFTER_B: begin
          if (byte_in == CH_SQ || byte_in == CH_DQ) begin
            quote_dbl_a = (byte_in == CH_DQ);
            byte_mode_a = 1'b1;
            phase_a     = PH_BODY;
          end else begin
            err_a = ST_PREFIX;
          end
        end
        PH_BODY: begin
          if (byte_in == qch) begin
            if (last_in) phase_a = PH_CLOSED;
            else err_a = ST_EARLY;
          end else if (byte_in == CH_BSL) begin
            phase_a = PH_ESC;
          end else if (byte_mode || !byte_in[7]) begin
            raw_req = 1'b1;
          end else if (byte_in[7:5] == 3'b110) begin
            cp_acc_a    = {16'd0, byte_in[4:0]};
            cont_left_a = 2'd1;
            phase_a     = PH_UTF;
          end else if (byte_in[7:4] == 4'b1110) begin
            cp_acc_a    = {17'd0, byte_in[3:0]};
            cont_left_a = 2'd2;
            phase_a     = PH_UTF;
          end else if (byte_in[7:3] == 5'b11110) begin
            cp_acc_a    = {18'd0, byte_in[2:0]};
            cont_left_a = 2'd3;
            phase_a     = PH_UTF;
          end else begin
            err_a = ST_UTF8;
          end
        end
        PH_ESC: begin
          if (byte_in == CH_X || byte_in == CH_U || byte_in == CH_UU) begin
            digits_left_a = (byte_in == CH_X) ? 4'd2 : (byte_in == CH_U) ? 4'd4 : 4'd8;
            hex_acc_a     = '0;
            phase_a       = PH_HEX;
          end else if (!sv[8]) begin
            err_a = ST_ESCAPE;
          end else begin
            emit_req = 1'b1;
            emit_v   = {24'd0, sv[7:0]};
            phase_a  = PH_BODY;
          end
        end
        PH_HEX: begin
          if (!hv[4]) begin
            err_a = ST_HEX;
          end else begin
            hex_acc_a     = {hex_acc[27:0], hv[3:0]};
            digits_left_a = digits_left - 4'd1;
            if (digits_left_a == 4'd0) begin
              emit_req = 1'b1;
              emit_v   = hex_acc_a;
              phase_a  = PH_BODY;
            end
          end
        end
        PH_UTF: begin
          if (byte_in[7:6] != 2'b10) begin
            err_a = ST_UTF8;
          end else begin
            cp_acc_a    = {cp_acc[14:0], byte_in[5:0]};
            cont_left_a = cont_left - 2'd1;
            if (cont_left_a == 2'd0) begin
              emit_req = 1'b1;
              emit_v   = {11'd0, cp_acc_a};
              phase_a  = PH_BODY;
            end
          end
        end
        default: begin
          // closed quote followed by more bytes
          err_a = ST_EARLY;
        end
      endcase
    end
  end

  assign enc = utf8_enc(emit_v);

  // emission, final status and return to start on the last byte
  always_comb begin
    phase_next       = phase_a;
    byte_mode_next   = byte_mode_a;
    quote_dbl_next   = quote_dbl_a;
    hex_acc_next     = hex_acc_a;
    digits_left_next = digits_left_a;
    cp_acc_next      = cp_acc_a;
    cont_left_next   = cont_left_a;
    err_next         = err_a;
    bnd              = '0;
    if (raw_req) begin
      bnd.bytes[0] = byte_in;
      bnd.nbytes   = 3'd1;
    end else if (emit_req) begin
      if (byte_mode) begin
        if (|emit_v[31:8]) begin
          err_next = ST_OVERFLOW;
        end else begin
          bnd.bytes[0] = emit_v[7:0];
          bnd.nbytes   = 3'd1;
        end
      end else begin
        bnd.bytes  = enc.bytes;
        bnd.nbytes = enc.nbytes;
      end
    end
    if (last_in) begin
      bnd.has_stat = 1'b1;
      if (err_next != ST_OK) begin
        bnd.stat = err_next;
      end else begin
        case (phase_next)
          PH_CLOSED:  bnd.stat = ST_OK;
          PH_AFTER_B: bnd.stat = ST_PREFIX;
          PH_ESC:     bnd.stat = ST_ESCAPE;
          PH_HEX:     bnd.stat = ST_HEX;
          PH_UTF:     bnd.stat = ST_UTF8;
          default:    bnd.stat = ST_UNCLOSED;
        endcase
      end
      phase_next       = PH_START;
      byte_mode_next   = 1'b0;
      quote_dbl_next   = 1'b0;
      hex_acc_next     = '0;
      digits_left_next = '0;
      cp_acc_next      = '0;
      cont_left_next   = '0;
      err_next         = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      byte_mode   <= 1'b0;
      quote_dbl   <= 1'b0;
      hex_acc     <= '0;
      digits_left <= '0;
      cp_acc      <= '0;
      cont_left   <= '0;
      err         <= ST_OK;
    end else if (accept) begin
      phase       <= phase_next;
      byte_mode   <= byte_mode_next;
      quote_dbl   <= quote_dbl_next;
      hex_acc     <= hex_acc_next;
      digits_left <= digits_left_next;
      cp_acc      <= cp_acc_next;
      cont_left   <= cont_left_next;
      err         <= err_next;
    end
  end

endmodule

>>> sv/qlu_emit.sv
// ----------------------------------------------------------------------------
// qlu_emit
// Result register: holds one bundle and hands its items out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module qlu_emit import qlu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bundle_t    bnd_in,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       done_res,
  output logic [2:0] status
);

  bundle_t    held;
  logic [2:0] total;
  logic [2:0] idx;
  logic       take;

  assign out_valid = (idx != total);
  assign take      = out_valid && out_ready;
  assign can_load  = !out_valid || (take && (idx + 3'd1 == total));

  always_comb begin
    if (idx < held.nbytes) begin
      out_byte   = held.bytes[idx[1:0]];
      byte_valid = 1'b1;
      done_res   = 1'b0;
      status     = ST_OK;
    end else begin
      out_byte   = 8'd0;
      byte_valid = 1'b0;
      done_res   = 1'b1;
      status     = held.stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      idx   <= '0;
    end else if (load) begin
      total <= bnd_in.nbytes + {2'd0, bnd_in.has_stat};
      idx   <= '0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= bnd_in;
  end

endmodule

>>> sv/quoted_literal_unescaper_core.sv
// ----------------------------------------------------------------------------
// quoted_literal_unescaper_core
// Streaming unescaper for one quoted literal (text or byte mode), one raw
// byte per transaction in, decoded bytes and a final status out.
//
//   channel | signals                                      | direction
//   in      | in_valid in_ready byte_in last_in            | consumer
//   out     | out_valid out_ready out_byte byte_valid      | producer
//           | done_res status                              |
//
// An input byte is decoded in the cycle it is accepted and its results land
// in the result register; they leave one per cycle while out_ready is high.
// A byte has up to four data results, plus a status result on the last byte.
// A byte with no results, or one whose single result is taken at once,
// lets the next byte in on the following cycle.
// in_ready is low while the held byte has results pending, except in the
// cycle its last result is taken.
// Reset returns the parser to the start of a literal with no error.
// ----------------------------------------------------------------------------
module quoted_literal_unescaper_core import qlu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       done_res,
  output logic [2:0] status
);

  bundle_t bnd;
  logic    accept;

  assign accept = in_valid && in_ready;

  qlu_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .byte_in (byte_in),
    .last_in (last_in),
    .bnd     (bnd)
  );

  qlu_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .bnd_in     (bnd),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .done_res   (done_res),
    .status     (status)
  );

endmodule

>>> sv/qlu_checker.sv
// ----------------------------------------------------------------------------
// qlu_checker
// Port-level checks for the quoted literal unescaper.
// ----------------------------------------------------------------------------
module qlu_checker import qlu_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] byte_in,
  input logic       last_in,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       done_res,
  input logic [2:0] status
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // every item is either data or status
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid ^ done_res))
    else $error("result item is neither data nor status");

  // data items carry no status
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> (status == ST_OK))
    else $error("data item with nonzero status");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(byte_valid) &&
       $stable(done_res) && $stable(status)))
    else $error("stalled result changed");

  // a waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(byte_in) && $stable(last_in)))
    else $error("stalled input changed");

endmodule

bind quoted_literal_unescaper_core qlu_checker u_qlu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .byte_in    (byte_in),
  .last_in    (last_in),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .done_res   (done_res),
  .status     (status)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quoted_literal_unescaper_core. A short directed
// table of literals is followed by random literals: mostly well-formed text
// and byte literals with random escapes and UTF-8, plus corrupted, truncated
// and pure-noise ones. Every accepted byte runs through a behavioral decoder
// that queues the expected output stream, which is compared in order against
// the DUT with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import qlu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS = 470;

  typedef struct packed {
    logic [7:0] b;
    logic       bv;
    logic       dn;
    logic [2:0] st;
  } res_t;

  typedef struct packed {
    logic [7:0] c;
    logic       l;
    logic       typed;
    logic [2:0] st;
  } vec_t;

  // typed rows carry their status; the other rows come from the decoder
  localparam vec_t DIR_TAB [29] = '{
    '{CH_X,   1'b1, 1'b1, ST_PREFIX},
    '{CH_B,   1'b1, 1'b1, ST_PREFIX},
    '{CH_B,   1'b0, 1'b0, ST_OK},
    '{CH_X,   1'b1, 1'b1, ST_PREFIX},
    '{CH_DQ,  1'b0, 1'b0, ST_OK},
    '{8'hFF,  1'b1, 1'b1, ST_UTF8},
    '{CH_SQ,  1'b0, 1'b0, ST_OK},
    '{CH_SQ,  1'b0, 1'b0, ST_OK},
    '{CH_X,   1'b1, 1'b1, ST_EARLY},
    '{CH_DQ,  1'b0, 1'b0, ST_OK},
    '{CH_BSL, 1'b1, 1'b1, ST_ESCAPE},
    '{CH_B,   1'b0, 1'b0, ST_OK},
    '{CH_SQ,  1'b0, 1'b0, ST_OK},
    '{CH_BSL, 1'b0, 1'b0, ST_OK},
    '{CH_U,   1'b0, 1'b0, ST_OK},
    '{8'h46,  1'b0, 1'b0, ST_OK},
    '{8'h66,  1'b0, 1'b0, ST_OK},
    '{8'h46,  1'b0, 1'b0, ST_OK},
    '{8'h66,  1'b1, 1'b1, ST_OVERFLOW},
    '{CH_SQ,  1'b0, 1'b0, ST_OK},
    '{8'hC0,  1'b0, 1'b0, ST_OK},
    '{8'h80,  1'b0, 1'b0, ST_OK},
    '{CH_SQ,  1'b1, 1'b0, ST_OK},
    '{CH_DQ,  1'b0, 1'b0, ST_OK},
    '{8'h00,  1'b1, 1'b0, ST_OK},
    '{CH_DQ,  1'b0, 1'b0, ST_OK},
    '{CH_BSL, 1'b0, 1'b0, ST_OK},
    '{CH_X,   1'b0, 1'b0, ST_OK},
    '{CH_DQ,  1'b1, 1'b1, ST_HEX}
  };

  localparam logic [7:0] ESC_CHARS [10] = '{
    CH_BSL, CH_SQ, CH_DQ, 8'h61, CH_B, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] byte_in;
  logic       last_in;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       done_res;
  logic [2:0] status;

  int   tx_idle_pct = 11;
  int   rx_idle_pct = 50;
  int   n_sent = 0;
  int   n_err = 0;
  res_t decoded_q [$];
  logic [7:0] lit_q [$];

  // decoder state
  phase_t      ph;
  logic        bmode;
  logic        dquote;
  logic [31:0] hacc;
  logic [3:0]  dleft;
  logic [20:0] cacc;
  logic [1:0]  cleft;
  logic [2:0]  err;

  quoted_literal_unescaper_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .byte_in   (byte_in),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .done_res  (done_res),
    .status    (status)
  );

  always #1 clk = ~clk;

  function automatic void clear_literal();
    ph     = PH_START;
    bmode  = 1'b0;
    dquote = 1'b0;
    hacc   = '0;
    dleft  = '0;
    cacc   = '0;
    cleft  = '0;
    err    = ST_OK;
  endfunction

  function automatic void append_result(input res_t r);
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function automatic void append_lit(input logic [7:0] c);
    lit_q.insert(lit_q.size(), c);
  endfunction

  function automatic void push_data(input logic [7:0] b);
    append_result('{b, 1'b1, 1'b0, ST_OK});
  endfunction

  function automatic void push_utf8(input logic [31:0] cp);
    if (cp < 32'h80) begin
      push_data(cp[7:0]);
    end else if (cp < 32'h800) begin
      push_data(8'hC0 | 8'(cp >> 6));
      push_data(8'h80 | 8'(cp & 32'h3F));
    end else if (cp < 32'h10000) begin
      push_data(8'hE0 | 8'(cp >> 12));
      push_data(8'h80 | 8'((cp >> 6) & 32'h3F));
      push_data(8'h80 | 8'(cp & 32'h3F));
    end else if (cp < 32'h110000) begin
      push_data(8'hF0 | 8'(cp >> 18));
      push_data(8'h80 | 8'((cp >> 12) & 32'h3F));
      push_data(8'h80 | 8'((cp >> 6) & 32'h3F));
      push_data(8'h80 | 8'(cp & 32'h3F));
    end
    // above the Unicode range: nothing comes out
  endfunction

  function automatic logic [2:0] emit_value(input logic [31:0] v);
    if (bmode) begin
      if (v > 32'hFF) return ST_OVERFLOW;
      push_data(v[7:0]);
      return ST_OK;
    end
    push_utf8(v);
    return ST_OK;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic int escape_code(input logic [7:0] c);
    for (int k = 0; k < 10; k++) begin
      if (c == ESC_CHARS[k]) begin
        case (k)
          0: return 'h5C;
          1: return 'h27;
          2: return 'h22;
          3: return 'h07;
          4: return 'h08;
          5: return 'h0C;
          6: return 'h0A;
          7: return 'h0D;
          8: return 'h09;
          default: return 'h0B;
        endcase
      end
    end
    return -1;
  endfunction

  // queue the results one accepted byte causes
  function automatic void unescape_byte(input logic [7:0] c, input logic l);
    int         h;
    logic [7:0] q;
    logic [2:0] st;
    if (err == ST_OK) begin
      q = dquote ? CH_DQ : CH_SQ;
      case (ph)
        PH_START: begin
          if (c == CH_B) begin
            ph = PH_AFTER_B;
          end else if (c == CH_SQ || c == CH_DQ) begin
            dquote = (c == CH_DQ);
            ph = PH_BODY;
          end else begin
            err = ST_PREFIX;
          end
        end
        PH_AFTER_B: begin
          if (c == CH_SQ || c == CH_DQ) begin
            dquote = (c == CH_DQ);
            bmode = 1'b1;
            ph = PH_BODY;
          end else begin
            err = ST_PREFIX;
          end
        end
        PH_BODY: begin
          if (c == q) begin
            if (l) ph = PH_CLOSED;
            else err = ST_EARLY;
          end else if (c == CH_BSL) begin
            ph = PH_ESC;
          end else if (bmode || !c[7]) begin
            push_data(c);
          end else if (c[7:5] == 3'b110) begin
            cacc = 21'(c[4:0]);
            cleft = 2'd1;
            ph = PH_UTF;
          end else if (c[7:4] == 4'b1110) begin
            cacc = 21'(c[3:0]);
            cleft = 2'd2;
            ph = PH_UTF;
          end else if (c[7:3] == 5'b11110) begin
            cacc = 21'(c[2:0]);
            cleft = 2'd3;
            ph = PH_UTF;
          end else begin
            err = ST_UTF8;
          end
        end
        PH_ESC: begin
          if (c == CH_X || c == CH_U || c == CH_UU) begin
            dleft = (c == CH_X) ? 4'd2 : (c == CH_U) ? 4'd4 : 4'd8;
            hacc = '0;
            ph = PH_HEX;
          end else if (escape_code(c) < 0) begin
            err = ST_ESCAPE;
          end else begin
            err = emit_value(32'(escape_code(c)));
            ph = PH_BODY;
          end
        end
        PH_HEX: begin
          h = hex_digit(c);
          if (h < 0) begin
            err = ST_HEX;
          end else begin
            hacc = {hacc[27:0], 4'(h)};
            dleft = dleft - 4'd1;
            if (dleft == 4'd0) begin
              err = emit_value(hacc);
              ph = PH_BODY;
            end
          end
        end
        PH_UTF: begin
          if (c[7:6] != 2'b10) begin
            err = ST_UTF8;
          end else begin
            cacc = {cacc[14:0], c[5:0]};
            cleft = cleft - 2'd1;
            if (cleft == 2'd0) begin
              push_utf8(32'(cacc));
              ph = PH_BODY;
            end
          end
        end
        default: err = ST_EARLY;
      endcase
    end
    if (l) begin
      st = err;
      if (err == ST_OK) begin
        case (ph)
          PH_CLOSED:  st = ST_OK;
          PH_AFTER_B: st = ST_PREFIX;
          PH_ESC:     st = ST_ESCAPE;
          PH_HEX:     st = ST_HEX;
          PH_UTF:     st = ST_UTF8;
          default:    st = ST_UNCLOSED;
        endcase
      end
      append_result('{8'h00, 1'b0, 1'b1, st});
      clear_literal();
    end
  endfunction

  function automatic void push_hex(input logic [31:0] v, input int nd);
    logic [3:0] nib;
    for (int k = nd - 1; k >= 0; k--) begin
      nib = v[4*k +: 4];
      if (nib < 4'd10) append_lit(8'h30 + 8'(nib));
      else if ($urandom_range(1) == 0) append_lit(8'h61 + 8'(nib) - 8'd10);
      else append_lit(8'h41 + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic logic [31:0] pick_codepoint();
    case ($urandom_range(6))
      0: return $urandom_range(32'h7F);
      1: return $urandom_range(32'h80, 32'h7FF);
      2: return $urandom_range(32'h800, 32'hFFFF);
      3: return $urandom_range(32'hD800, 32'hDFFF);
      4: return $urandom_range(32'h10000, 32'h10FFFF);
      5: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return 32'h0;
          1: return 32'h10FFFF;
          2: return 32'h110000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic void add_piece(input logic bm, input logic [7:0] q);
    logic [7:0]  c;
    logic [31:0] v;
    int          nb;
    case ($urandom_range(9))
      0, 1, 2: begin
        c = bm ? 8'($urandom_range(255)) : 8'($urandom_range(127));
        if (c == q || c == CH_BSL) c = 8'h41;
        append_lit(c);
      end
      3: begin
        append_lit(CH_BSL);
        append_lit(ESC_CHARS[$urandom_range(9)]);
      end
      4: begin
        append_lit(CH_BSL);
        append_lit(CH_X);
        push_hex($urandom, 2);
      end
      5, 6: begin
        v = pick_codepoint();
        // byte literals stay mostly in range so they get past the escape
        if (bm && $urandom_range(3) != 0) v = v & 32'hFF;
        append_lit(CH_BSL);
        if (v <= 32'hFFFF && $urandom_range(1) == 0) begin
          append_lit(CH_U);
          push_hex(v, 4);
        end else begin
          append_lit(CH_UU);
          push_hex(v, 8);
        end
      end
      default: begin
        if (bm) begin
          append_lit(8'($urandom_range(8'h80, 8'hFF)));
        end else begin
          // random payload bits, so short values give overlong forms
          nb = $urandom_range(2, 4);
          v = $urandom;
          case (nb)
            2: append_lit(8'hC0 | 8'(v[4:0]));
            3: append_lit(8'hE0 | 8'(v[3:0]));
            default: append_lit(8'hF0 | 8'(v[2:0]));
          endcase
          for (int k = 1; k < nb; k++) append_lit(8'h80 | 8'(v[6*k +: 6]));
        end
      end
    endcase
  endfunction

  function automatic void build_literal();
    int         pick;
    int         n;
    logic       bm;
    logic [7:0] q;
    lit_q.delete();
    pick = $urandom_range(99);
    if (pick < 10) begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(3))
          0: append_lit(CH_B);
          1: append_lit(CH_SQ);
          2: append_lit(CH_DQ);
          default: append_lit(8'($urandom));
        endcase
      end
      return;
    end
    bm = ($urandom_range(2) == 0);
    q = ($urandom_range(1) == 0) ? CH_DQ : CH_SQ;
    if (bm) append_lit(CH_B);
    append_lit(q);
    n = $urandom_range(0, 6);
    for (int k = 0; k < n; k++) add_piece(bm, q);
    append_lit(q);
    if (pick < 32) begin
      case ($urandom_range(2))
        0: lit_q[$urandom_range(lit_q.size() - 1)] = 8'($urandom);
        1: begin
          n = $urandom_range(1, lit_q.size() - 1);
          while (lit_q.size() > n) void'(lit_q.pop_back());
        end
        default: lit_q[$urandom_range(lit_q.size() - 1)] = q;
      endcase
    end
  endfunction

  // one input transaction; starts and returns at a rising edge
  task automatic send_byte(input logic [7:0] c, input logic l, input logic typed,
                           input logic [2:0] st);
    if (n_sent < N_ITEMS / 3) begin
      tx_idle_pct = 11;
      rx_idle_pct = 50;
    end else if (n_sent < 2 * N_ITEMS / 3) begin
      tx_idle_pct = 50;
      rx_idle_pct = 11;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= c;
    last_in  <= l;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    unescape_byte(c, l);
    if (typed) begin
      void'(decoded_q.pop_back());
      append_result('{8'h00, 1'b0, 1'b1, st});
    end
    n_sent++;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // signals are settled at the falling edge; a transaction here completes
  // at the next rising edge
  always @(negedge clk) begin
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected result: byte=%h bv=%b done=%b st=%0d",
                   out_byte, byte_valid, done_res, status);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.b || byte_valid !== want.bv || done_res !== want.dn ||
            status !== want.st) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: got %h/%b/%b/%0d, exp %h/%b/%b/%0d",
                     out_byte, byte_valid, done_res, status,
                     want.b, want.bv, want.dn, want.st);
        end
      end
    end
  end

  initial begin
    #500_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    byte_in  = 8'h00;
    last_in  = 1'b0;
    clear_literal();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIR_TAB); i++)
      send_byte(DIR_TAB[i].c, DIR_TAB[i].l, DIR_TAB[i].typed, DIR_TAB[i].st);

    while (n_sent < N_ITEMS) begin
      build_literal();
      for (int i = 0; i < lit_q.size(); i++)
        send_byte(lit_q[i], i == lit_q.size() - 1, 1'b0, ST_OK);
    end

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0 && decoded_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
sv/qlu_pkg.sv
sv/qlu_parse.sv
sv/qlu_emit.sv
sv/quoted_literal_unescaper_core.sv
sv/qlu_checker.sv
tb/sv/tb_top.sv
